### rtl/core/itls_pkg.sv
// ----------------------------------------------------------------------------
// itls_pkg
// Types and operation codes shared by the I-type execute/load-store unit.
// ----------------------------------------------------------------------------
`default_nettype none

package itls_pkg;

	localparam logic [3:0] KIND_ADDI  = 4'd0;
	localparam logic [3:0] KIND_ADDIU = 4'd1;
	localparam logic [3:0] KIND_SLTI  = 4'd2;
	localparam logic [3:0] KIND_ANDI  = 4'd3;
	localparam logic [3:0] KIND_ORI   = 4'd4;
	localparam logic [3:0] KIND_NORI  = 4'd5;
	localparam logic [3:0] KIND_LUI   = 4'd6;
	localparam logic [3:0] KIND_LW    = 4'd7;
	localparam logic [3:0] KIND_LH    = 4'd8;
	localparam logic [3:0] KIND_LHU   = 4'd9;
	localparam logic [3:0] KIND_LB    = 4'd10;
	localparam logic [3:0] KIND_LBU   = 4'd11;
	localparam logic [3:0] KIND_SW    = 4'd12;
	localparam logic [3:0] KIND_SH    = 4'd13;
	localparam logic [3:0] KIND_SB    = 4'd14;

	typedef struct packed {
		logic [3:0]         kind;
		logic [31:0]        rs_value;
		logic signed [15:0] imm;
		logic [31:0]        store_data;
		logic [31:0]        mem_word;
	} req_t;

	typedef struct packed {
		logic [31:0] alu_value;
		logic [31:0] load_data;
		logic [31:0] write_word;
		logic        reg_write;
		logic        mem_read;
		logic        mem_write;
	} rsp_t;

	typedef struct packed {
		logic reg_write;
		logic mem_read;
		logic mem_write;
	} ctl_t;

endpackage

`default_nettype wire

### rtl/core/itls_alu.sv
// ----------------------------------------------------------------------------
// itls_alu
// Immediate ALU, effective address and control flag decode.
// ----------------------------------------------------------------------------
`default_nettype none

module itls_alu (
	input  wire logic [3:0]         kind,
	input  wire logic [31:0]        rs_value,
	input  wire logic signed [15:0] imm,
	output logic [31:0]             alu_value,
	output logic [1:0]              addr_lsb,
	output itls_pkg::ctl_t          ctl
);
	import itls_pkg::*;

	logic [31:0] simm;
	logic [31:0] zimm;
	logic [31:0] addr;

	assign simm     = {{16{imm[15]}}, imm};
	assign zimm     = {16'h0000, imm};
	assign addr     = rs_value + simm;
	assign addr_lsb = addr[1:0];

	always_comb begin
		case (kind)
			KIND_SLTI: alu_value = {31'd0, $signed(rs_value) < $signed(simm)};
			KIND_ANDI: alu_value = rs_value & zimm;
			KIND_ORI:  alu_value = rs_value | zimm;
			KIND_NORI: alu_value = ~(rs_value | zimm);
			KIND_LUI:  alu_value = {imm, 16'h0000};
			default: begin
				if (kind inside {KIND_ADDI, KIND_ADDIU, [KIND_LW:KIND_SB]}) begin
					alu_value = addr;
				end else begin
					alu_value = '0;
				end
			end
		endcase
	end

	always_comb begin
		ctl.reg_write = kind inside {[KIND_ADDI:KIND_LBU]};
		ctl.mem_read  = kind inside {[KIND_LW:KIND_LBU]};
		ctl.mem_write = kind inside {[KIND_SW:KIND_SB]};
	end

endmodule

`default_nettype wire

### rtl/core/itls_lane.sv
// ----------------------------------------------------------------------------
// itls_lane
// Big-endian byte/halfword lane extract for loads and merge for stores.
// ----------------------------------------------------------------------------
`default_nettype none

module itls_lane (
	input  wire logic [3:0]  kind,
	input  wire logic [1:0]  addr_lsb,
	input  wire logic [31:0] store_data,
	input  wire logic [31:0] mem_word,
	output logic [31:0]      load_data,
	output logic [31:0]      write_word
);
	import itls_pkg::*;

	logic [7:0]  byte_v;
	logic [15:0] half_v;
	logic [31:0] byte_merge;
	logic [31:0] half_merge;

	always_comb begin
		case (addr_lsb)
			2'd0: begin
				byte_v     = mem_word[31:24];
				byte_merge = {store_data[7:0], mem_word[23:0]};
			end
			2'd1: begin
				byte_v     = mem_word[23:16];
				byte_merge = {mem_word[31:24], store_data[7:0], mem_word[15:0]};
			end
			2'd2: begin
				byte_v     = mem_word[15:8];
				byte_merge = {mem_word[31:16], store_data[7:0], mem_word[7:0]};
			end
			default: begin
				byte_v     = mem_word[7:0];
				byte_merge = {mem_word[31:8], store_data[7:0]};
			end
		endcase
	end

	// bit 0 ignored for halfwords
	always_comb begin
		if (addr_lsb[1]) begin
			half_v     = mem_word[15:0];
			half_merge = {mem_word[31:16], store_data[15:0]};
		end else begin
			half_v     = mem_word[31:16];
			half_merge = {store_data[15:0], mem_word[15:0]};
		end
	end

	always_comb begin
		load_data  = '0;
		write_word = '0;
		case (kind)
			KIND_LW:  load_data  = mem_word;
			KIND_LH:  load_data  = {{16{half_v[15]}}, half_v};
			KIND_LHU: load_data  = {16'h0000, half_v};
			KIND_LB:  load_data  = {{24{byte_v[7]}}, byte_v};
			KIND_LBU: load_data  = {24'h000000, byte_v};
			KIND_SW:  write_word = store_data;
			KIND_SH:  write_word = half_merge;
			KIND_SB:  write_word = byte_merge;
			default: begin
				load_data  = '0;
				write_word = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/i_type_execute_load_store_unit.sv
// ----------------------------------------------------------------------------
// i_type_execute_load_store_unit
// Execute/memory-lane stage for non-branch MIPS I-type operations.
//
// Request channel (req_valid/req_stall/req) carries the operation kind, rs
// value, immediate, store data and the big-endian memory word at the
// formed address. Response channel (rsp_valid/rsp_stall/rsp) returns the
// ALU result or effective address, extended load data, merged store word
// and the reg_write/mem_read/mem_write flags.
//
// A request is captured in the input register, the ALU and lane logic
// work on it combinationally and the result lands in the output register.
// Throughput is one request per cycle while rsp_stall is low.
// When rsp_stall is high the response holds; the input register still
// accepts one more request, and req_stall rises only once both registers
// hold work. Reset clears both valid flags; no request is lost or repeated.
// Kind 15 yields an all-zero response.
// ----------------------------------------------------------------------------
`default_nettype none

module i_type_execute_load_store_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire itls_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output itls_pkg::rsp_t       rsp
);
	import itls_pkg::*;

	logic        valid_s1;
	req_t        req_s1;
	logic        adv_s2;
	logic [31:0] alu_value;
	logic [1:0]  addr_lsb;
	ctl_t        ctl;
	logic [31:0] load_data;
	logic [31:0] write_word;

	assign adv_s2    = !rsp_valid || !rsp_stall;
	assign req_stall = valid_s1 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	itls_alu u_alu (
		.kind       (req_s1.kind),
		.rs_value   (req_s1.rs_value),
		.imm        (req_s1.imm),
		.alu_value  (alu_value),
		.addr_lsb   (addr_lsb),
		.ctl        (ctl)
	);

	itls_lane u_lane (
		.kind       (req_s1.kind),
		.addr_lsb   (addr_lsb),
		.store_data (req_s1.store_data),
		.mem_word   (req_s1.mem_word),
		.load_data  (load_data),
		.write_word (write_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv_s2) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rsp.alu_value  <= alu_value;
			rsp.load_data  <= load_data;
			rsp.write_word <= write_word;
			rsp.reg_write  <= ctl.reg_write;
			rsp.mem_read   <= ctl.mem_read;
			rsp.mem_write  <= ctl.mem_write;
		end
	end

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.mem_read && rsp.mem_write) && !(rsp.reg_write && rsp.mem_write))
		else $error("load and store flags both set");

	a_load_wb: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.mem_read |-> rsp.reg_write)
		else $error("load without register write");

	a_zero_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.mem_read || rsp.load_data == '0) &&
			(rsp.mem_write || rsp.write_word == '0))
		else $error("lane data set for non-memory op");

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> valid_s1)
		else $error("accepted request not captured");

endmodule

`default_nettype wire
